// ===== src/pot_scan_change_detect_macros.svh =====
// Assertion macros for the pot scanner RTL.
// Depends on nothing; included by pscd_evser, which checks its own logic.
`ifndef POT_SCAN_CHANGE_DETECT_MACROS_SVH
`define POT_SCAN_CHANGE_DETECT_MACROS_SVH

// same-cycle implication
`define PSCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pscd_pkg.sv =====
// Package for the pot scanner: field widths, defaults and the frame record type.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pscd_pkg;

	localparam int SAMPLE_W       = 12;
	localparam int VALUE_W        = 7;
	localparam int VALUE_SHIFT    = 5;
	localparam int POT_W          = 5;
	localparam int MSEL_W         = 3;
	localparam int IN_FIELDS      = 4;
	localparam int LANE_W         = $clog2(IN_FIELDS);
	localparam int DEF_NUM_GROUPS = 8;
	localparam int DEF_CHANNELS   = 4;

	typedef logic [IN_FIELDS-1:0][VALUE_W-1:0] val_vec_t;

	typedef struct packed {
		logic [IN_FIELDS-1:0] chg;
		val_vec_t             val;
		logic [POT_W-1:0]     base;
		logic [MSEL_W-1:0]    msel;
	} frm_t;

endpackage

`default_nettype wire

// ===== src/pot_scan_change_detect.sv =====
// Top level of the multiplexed pot scanner with change detection.
// Depends on pscd_pkg, pscd_detect and pscd_evser.
//
// Usage:
//   s_* carries one conversion frame per beat: four 12-bit samples of the
//   current mux group. m_* carries change events: pot index, new 7-bit value,
//   next mux select, with tuser[0] = changed and tlast on the final event of
//   the frame. A frame with no change gives a single beat with changed low.
//   A frame passes the input register and then the event buffer register
//   before its first event shows on m_*. The event buffer emits one change
//   per output beat, so a frame gives one beat per event it produces (1 to
//   4); the next frame is taken into the input register while the current frame's events drain.
//   Reset clears the last-value store to zero, the group select to zero and
//   all valid flags. When the receiver stalls, the event buffer holds its
//   beat, one more frame waits in the input register, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module pot_scan_change_detect #(
	parameter int NUM_GROUPS = pscd_pkg::DEF_NUM_GROUPS,
	parameter int CHANNELS   = pscd_pkg::DEF_CHANNELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // sample_0[11:0], sample_1[23:12], sample_2[35:24], sample_3[47:36]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // pot_index[4:0], pot_value[11:5], mux_select[14:12]
	output logic [0:0]       m_tuser,  // changed[0]
	output logic             m_tlast
);

	logic               valid_s1;
	pscd_pkg::val_vec_t val_s1;
	pscd_pkg::val_vec_t val_in;
	pscd_pkg::frm_t     frm;
	logic               ser_ready;
	logic               advance;

	always_comb begin
		for (int c = 0; c < pscd_pkg::IN_FIELDS; c++) begin
			val_in[c] = s_tdata[c*pscd_pkg::SAMPLE_W + pscd_pkg::VALUE_SHIFT +: pscd_pkg::VALUE_W];
		end
	end

	assign advance  = valid_s1 && ser_ready;
	assign s_tready = !valid_s1 || ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			val_s1 <= val_in;
		end
	end

	pscd_detect #(
		.NUM_GROUPS(NUM_GROUPS),
		.CHANNELS  (CHANNELS)
	) u_detect (
		.clk    (clk),
		.arst_n (arst_n),
		.val_s1 (val_s1),
		.advance(advance),
		.frm    (frm)
	);

	pscd_evser u_evser (
		.clk     (clk),
		.arst_n  (arst_n),
		.frm     (frm),
		.in_valid(valid_s1),
		.in_ready(ser_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire

// ===== src/pscd_detect.sv =====
// Last-value store, group select counter and per-channel change compare.
// Depends on pscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pscd_detect #(
	parameter int NUM_GROUPS = pscd_pkg::DEF_NUM_GROUPS,
	parameter int CHANNELS   = pscd_pkg::DEF_CHANNELS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pscd_pkg::val_vec_t val_s1,
	input  wire logic              advance,
	output pscd_pkg::frm_t         frm
);

	localparam int SCAN   = (CHANNELS < pscd_pkg::IN_FIELDS) ? CHANNELS : pscd_pkg::IN_FIELDS;
	localparam int SEL_W  = (NUM_GROUPS > 2) ? $clog2(NUM_GROUPS) : 1;
	localparam int FULL_W = $clog2(NUM_GROUPS * CHANNELS) + 1;

	logic [pscd_pkg::VALUE_W-1:0] store_q [SCAN][NUM_GROUPS];
	logic [SEL_W-1:0]             sel_q;
	logic [SEL_W-1:0]             sel_next;
	logic [FULL_W-1:0]            base_full;

	assign sel_next  = (sel_q == SEL_W'(NUM_GROUPS - 1)) ? '0 : sel_q + 1'b1;
	assign base_full = FULL_W'(sel_q) * FULL_W'(CHANNELS);

	always_comb begin
		frm      = '0;
		frm.base = pscd_pkg::POT_W'(base_full);
		frm.msel = pscd_pkg::MSEL_W'(sel_next);
		for (int c = 0; c < SCAN; c++) begin
			frm.val[c] = val_s1[c];
			frm.chg[c] = (store_q[c][sel_q] != val_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
			for (int c = 0; c < SCAN; c++) begin
				for (int g = 0; g < NUM_GROUPS; g++) begin
					store_q[c][g] <= '0;
				end
			end
		end else if (advance) begin
			sel_q <= sel_next;
			for (int c = 0; c < SCAN; c++) begin
				if (frm.chg[c]) begin
					store_q[c][sel_q] <= val_s1[c];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/pscd_evser.sv =====
// Event buffer: holds one frame's change record and emits one beat per change, or one no-change beat.
// Depends on pscd_pkg and pot_scan_change_detect_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pot_scan_change_detect_macros.svh"

module pscd_evser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pscd_pkg::frm_t frm,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [15:0]        m_tdata,  // pot_index[4:0], pot_value[11:5], mux_select[14:12]
	output logic [0:0]         m_tuser,  // changed[0]
	output logic               m_tlast
);

	logic                                   valid_q;
	logic [pscd_pkg::IN_FIELDS-1:0]         pend_q;
	pscd_pkg::val_vec_t                     val_q;
	logic [pscd_pkg::POT_W-1:0]             base_q;
	logic [pscd_pkg::MSEL_W-1:0]            msel_q;
	logic [pscd_pkg::IN_FIELDS-1:0]         rest;
	logic [pscd_pkg::LANE_W-1:0]            idx;
	logic                                   found;
	logic                                   chg;
	logic                                   fin;
	logic                                   beat;
	logic                                   load;
	logic [pscd_pkg::POT_W-1:0]             pot_index;
	logic [pscd_pkg::VALUE_W-1:0]           pot_value;

	always_comb begin
		idx   = '0;
		found = 1'b0;
		for (int i = 0; i < pscd_pkg::IN_FIELDS; i++) begin
			if (pend_q[i] && !found) begin
				idx   = pscd_pkg::LANE_W'(i);
				found = 1'b1;
			end
		end
	end

	assign rest      = pend_q & (pend_q - 1'b1);
	assign chg       = |pend_q;
	assign fin       = (rest == '0);
	assign beat      = valid_q && m_tready;
	assign in_ready  = !valid_q || (m_tready && fin);
	assign load      = in_valid && in_ready;
	assign pot_index = chg ? base_q + pscd_pkg::POT_W'(idx) : '0;
	assign pot_value = chg ? val_q[idx] : '0;

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, msel_q, pot_value, pot_index};
	assign m_tuser  = chg;
	assign m_tlast  = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			pend_q  <= frm.chg;
		end else if (beat) begin
			pend_q <= rest;
			if (fin) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q  <= frm.val;
			base_q <= frm.base;
			msel_q <= frm.msel;
		end
	end

	`PSCD_ASSERT_NOW(a_nochg_is_last, clk, arst_n, valid_q && !chg, fin, "no-change beat not last")
	`PSCD_ASSERT_NEXT(a_more_follow, clk, arst_n, beat && !fin, valid_q && chg, "frame events lost")
	`PSCD_ASSERT_NEXT(a_drain_empty, clk, arst_n, beat && fin && !load, !valid_q, "beat repeated")
	`PSCD_ASSERT_NEXT(a_msel_hold, clk, arst_n, beat && !fin, $stable(msel_q), "select moved mid-frame")

endmodule

`default_nettype wire
